### src/mhpq_pkg.sv
package mhpq_pkg;

    // Field widths fixed by the item format.
    localparam int VERTEX_W = 16;
    localparam int COST_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // Default heap capacity and depth of the command queue.
    localparam int DEFAULT_CAPACITY = 64;
    localparam int QUEUE_DEPTH      = 2;

    // Status codes carried with every result.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Opcode values of the op field.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // What the back end has to do with a command.
    typedef enum logic [1:0] {
        KIND_INSERT,
        KIND_EXTRACT,
        KIND_ERROR
    } t_kind;

    // One classified command passed from the front end to the back end.
    typedef struct packed {
        t_kind                kind;
        logic [VERTEX_W-1:0]  vertex;
        logic [COST_W-1:0]    cost;
        logic [STATUS_W-1:0]  status;
        logic [OCC_W-1:0]     occupancy;
    } t_cmd;

    // One heap entry as held in the store.
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [COST_W-1:0]   cost;
    } t_entry;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_EX_TOP,
        S_EX_LAST,
        S_EX_GETX,
        S_EX_LEFT,
        S_EX_RIGHT,
        S_EX_CMP,
        S_DONE
    } t_state;

endpackage

### src/mhpq_front.sv
module mhpq_front #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_op,
    input  logic [mhpq_pkg::VERTEX_W-1:0] i_vertex_id,
    input  logic [mhpq_pkg::COST_W-1:0]   i_cost,
    output logic                          o_push,
    output mhpq_pkg::t_cmd                o_cmd
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Classify the beat against the running entry count and work out
    // the occupancy it leaves, so the back end only has to execute it.
    always_comb begin
        n_count        = r_count;
        o_cmd.vertex   = i_vertex_id;
        o_cmd.cost     = i_cost;
        o_cmd.kind     = mhpq_pkg::KIND_ERROR;
        o_cmd.status   = mhpq_pkg::STATUS_OK;
        if (i_op == mhpq_pkg::OP_INSERT) begin
            if (r_count == CW'(CAPACITY)) begin
                o_cmd.status = mhpq_pkg::STATUS_FULL;
            end else begin
                o_cmd.kind = mhpq_pkg::KIND_INSERT;
                n_count    = r_count + CW'(1);
            end
        end else begin
            if (r_count == '0) begin
                o_cmd.status = mhpq_pkg::STATUS_EMPTY;
            end else begin
                o_cmd.kind = mhpq_pkg::KIND_EXTRACT;
                n_count    = r_count - CW'(1);
            end
        end
        o_cmd.occupancy = mhpq_pkg::OCC_W'(n_count);
    end

    assign o_push = i_accept;

    // Entry count as seen by accepted beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

endmodule

### src/mhpq_queue.sv
module mhpq_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mhpq_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output mhpq_pkg::t_cmd o_cmd
);

    localparam int DEPTH = mhpq_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    mhpq_pkg::t_cmd r_slot [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [NW-1:0]  r_fill;

    assign o_full  = (r_fill == NW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + NW'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - NW'(1);
            end
        end
    end

    // Command slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### src/mhpq_back.sv
module mhpq_back #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  mhpq_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    output logic                          o_done,
    output logic [mhpq_pkg::VERTEX_W-1:0] o_out_vertex,
    output logic [mhpq_pkg::COST_W-1:0]   o_out_cost,
    output logic [mhpq_pkg::STATUS_W-1:0] o_status,
    output logic [mhpq_pkg::OCC_W-1:0]    o_occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;

    // Heap store with one write and one registered read port.
    mhpq_pkg::t_entry r_mem [CAPACITY];
    mhpq_pkg::t_entry r_rdata;
    mhpq_pkg::t_entry wr_data;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;

    mhpq_pkg::t_state r_state;
    mhpq_pkg::t_state n_state;
    logic [CW-1:0]    r_size;
    logic [CW-1:0]    n_size;
    logic [AW-1:0]    r_pos;
    logic [AW-1:0]    n_pos;
    mhpq_pkg::t_entry r_item;
    mhpq_pkg::t_entry n_item;
    mhpq_pkg::t_entry r_child;
    mhpq_pkg::t_entry n_child;
    mhpq_pkg::t_entry r_top;
    mhpq_pkg::t_entry n_top;
    logic [mhpq_pkg::STATUS_W-1:0] r_status;
    logic [mhpq_pkg::STATUS_W-1:0] n_status;
    logic [mhpq_pkg::OCC_W-1:0]    r_occ;
    logic [mhpq_pkg::OCC_W-1:0]    n_occ;

    // Tree navigation around the current hole position.
    logic [LW-1:0]    left_w;
    logic [LW-1:0]    right_w;
    logic [LW-1:0]    size_w;
    logic [AW-1:0]    left_idx;
    logic [AW-1:0]    right_idx;
    logic [AW-1:0]    parent_idx;
    logic             has_left;
    logic             has_right;
    logic             take_right;
    mhpq_pkg::t_entry sel_entry;
    logic [AW-1:0]    sel_idx;
    logic             sel_less;
    logic             ins_less;

    assign left_w     = LW'({r_pos, 1'b1});
    assign right_w    = left_w + LW'(1);
    assign size_w     = LW'(r_size);
    assign left_idx   = left_w[AW-1:0];
    assign right_idx  = right_w[AW-1:0];
    assign parent_idx = (r_pos - AW'(1)) >> 1;
    assign has_left   = (left_w < size_w);
    assign has_right  = (right_w < size_w);

    // Pick the smaller child; the right one only wins when strictly smaller.
    assign take_right = has_right && ($signed(r_rdata.cost) < $signed(r_child.cost));
    assign sel_entry  = take_right ? r_rdata : r_child;
    assign sel_idx    = take_right ? right_idx : left_idx;
    assign sel_less   = ($signed(sel_entry.cost) < $signed(r_item.cost));
    assign ins_less   = ($signed(r_item.cost) < $signed(r_rdata.cost));

    assign o_pop = (r_state == mhpq_pkg::S_IDLE) && i_cmd_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        mhpq_pkg::KIND_INSERT:  n_state = mhpq_pkg::S_INS_RD;
                        mhpq_pkg::KIND_EXTRACT: n_state = mhpq_pkg::S_EX_TOP;
                        default:                n_state = mhpq_pkg::S_DONE;
                    endcase
                end
            end
            mhpq_pkg::S_INS_RD: begin
                n_state = (r_pos == '0) ? mhpq_pkg::S_DONE : mhpq_pkg::S_INS_CMP;
            end
            mhpq_pkg::S_INS_CMP: begin
                n_state = ins_less ? mhpq_pkg::S_INS_RD : mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_EX_TOP:   n_state = mhpq_pkg::S_EX_LAST;
            mhpq_pkg::S_EX_LAST:  n_state = mhpq_pkg::S_EX_GETX;
            mhpq_pkg::S_EX_GETX:  n_state = mhpq_pkg::S_EX_LEFT;
            mhpq_pkg::S_EX_LEFT: begin
                n_state = has_left ? mhpq_pkg::S_EX_RIGHT : mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_EX_RIGHT: n_state = mhpq_pkg::S_EX_CMP;
            mhpq_pkg::S_EX_CMP: begin
                n_state = sel_less ? mhpq_pkg::S_EX_LEFT : mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_DONE:     n_state = mhpq_pkg::S_IDLE;
            default:              n_state = mhpq_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory port controls and result fields.
    always_comb begin
        n_size   = r_size;
        n_pos    = r_pos;
        n_item   = r_item;
        n_child  = r_child;
        n_top    = r_top;
        n_status = r_status;
        n_occ    = r_occ;
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_item;
        rd_addr  = '0;
        case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    n_status      = i_cmd.status;
                    n_occ         = i_cmd.occupancy;
                    n_top         = '0;
                    n_item.vertex = i_cmd.vertex;
                    n_item.cost   = i_cmd.cost;
                    if (i_cmd.kind == mhpq_pkg::KIND_INSERT) begin
                        n_pos  = r_size[AW-1:0];
                        n_size = r_size + CW'(1);
                    end else if (i_cmd.kind == mhpq_pkg::KIND_EXTRACT) begin
                        n_size = r_size - CW'(1);
                    end
                end
            end
            mhpq_pkg::S_INS_RD: begin
                // At the root the new pair lands; otherwise fetch the parent.
                if (r_pos == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_addr = parent_idx;
                end
            end
            mhpq_pkg::S_INS_CMP: begin
                // A strictly greater parent moves down into the hole.
                wr_en = 1'b1;
                if (ins_less) begin
                    wr_data = r_rdata;
                    n_pos   = parent_idx;
                end
            end
            mhpq_pkg::S_EX_TOP: begin
                rd_addr = '0;
            end
            mhpq_pkg::S_EX_LAST: begin
                rd_addr = r_size[AW-1:0];
                n_top   = r_rdata;
            end
            mhpq_pkg::S_EX_GETX: begin
                n_item = r_rdata;
                n_pos  = '0;
            end
            mhpq_pkg::S_EX_LEFT: begin
                if (has_left) begin
                    rd_addr = left_idx;
                end else begin
                    wr_en = 1'b1;
                end
            end
            mhpq_pkg::S_EX_RIGHT: begin
                n_child = r_rdata;
                rd_addr = right_idx;
            end
            mhpq_pkg::S_EX_CMP: begin
                // A strictly smaller child moves up into the hole.
                wr_en = 1'b1;
                if (sel_less) begin
                    wr_data = sel_entry;
                    n_pos   = sel_idx;
                end
            end
            default: begin
            end
        endcase
    end

    // Result beat, one cycle wide.
    assign o_done       = (r_state == mhpq_pkg::S_DONE);
    assign o_out_vertex = r_top.vertex;
    assign o_out_cost   = r_top.cost;
    assign o_status     = r_status;
    assign o_occupancy  = r_occ;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
            r_size  <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_item   <= n_item;
        r_child  <= n_child;
        r_top    <= n_top;
        r_status <= n_status;
        r_occ    <= n_occ;
    end

    // Heap store.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

endmodule

### src/min_heap_priority_queue.sv
// Binary min-heap priority queue of (vertex, cost) pairs.
//
// Command channel: a beat is taken on a rising edge with start high and
// busy low. i_op selects insert (0) or extract-minimum (1); i_vertex_id
// and i_cost carry the pair to insert and are ignored on extract.
// Result channel: every command gives exactly one result, in command order,
// shown for one cycle with o_done high. o_out_vertex/o_out_cost carry the
// extracted pair (zero for inserts and errors), o_status gives ok, extract
// from empty or insert into full, o_occupancy the entry count afterward.
// The receiver cannot stall; results must be taken when o_done is high.
//
// A front end classifies each beat against its own entry count and places
// it in a two-deep command queue; busy is high while that queue is full.
// The back end runs the sift through the heap memory with a registered read.
// An insert moves the new pair up past each strictly costlier parent; an
// extract moves the last entry to the root and sinks it level by level until
// a child compare stops it or it reaches a leaf. The back end takes the next
// queued command only once idle. Reset empties the heap and the queue.
module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [mhpq_pkg::VERTEX_W-1:0] i_vertex_id,
    input  logic [mhpq_pkg::COST_W-1:0]   i_cost,
    output logic                          o_done,
    output logic [mhpq_pkg::VERTEX_W-1:0] o_out_vertex,
    output logic [mhpq_pkg::COST_W-1:0]   o_out_cost,
    output logic [mhpq_pkg::STATUS_W-1:0] o_status,
    output logic [mhpq_pkg::OCC_W-1:0]    o_occupancy
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    mhpq_pkg::t_cmd front_cmd;
    mhpq_pkg::t_cmd back_cmd;

    assign busy   = q_full;
    assign accept = start && !q_full;

    // Classifies command beats.
    mhpq_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_vertex_id (i_vertex_id),
        .i_cost      (i_cost),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // Decouples the front end from the heap engine.
    mhpq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    // Executes heap operations and produces results.
    mhpq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (back_cmd),
        .o_pop        (pop),
        .o_done       (o_done),
        .o_out_vertex (o_out_vertex),
        .o_out_cost   (o_out_cost),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule

### tb/heap_result_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the heap queue, keeps its own
// copy of the heap to predict each result, and compares every result beat
// with the oldest prediction.
module heap_result_checker #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_op,
    input  logic [mhpq_pkg::VERTEX_W-1:0] i_vertex_id,
    input  logic [mhpq_pkg::COST_W-1:0]   i_cost,
    input  logic                          i_done,
    input  logic [mhpq_pkg::VERTEX_W-1:0] i_out_vertex,
    input  logic [mhpq_pkg::COST_W-1:0]   i_out_cost,
    input  logic [mhpq_pkg::STATUS_W-1:0] i_status,
    input  logic [mhpq_pkg::OCC_W-1:0]    i_occupancy,
    output int                            o_fail_count,
    output int                            o_outstanding,
    output int                            o_results_seen,
    output int                            o_pairs_seen,
    output int                            o_empty_seen,
    output int                            o_full_seen
);

    typedef struct packed {
        logic                          extracted;
        logic [mhpq_pkg::VERTEX_W-1:0] vertex;
        logic [mhpq_pkg::COST_W-1:0]   cost;
        logic [mhpq_pkg::STATUS_W-1:0] status;
        logic [mhpq_pkg::OCC_W-1:0]    occupancy;
    } t_heap_result;

    // Shadow heap and the results it has predicted but not yet seen.
    mhpq_pkg::t_entry shadow_heap [CAPACITY];
    int unsigned      shadow_count;
    t_heap_result     expected_results [$];

    // Applies one command to the shadow heap and returns the result it gives.
    function automatic t_heap_result predict_heap_op(
        input logic                          op,
        input logic [mhpq_pkg::VERTEX_W-1:0] vertex,
        input logic [mhpq_pkg::COST_W-1:0]   cost
    );
        t_heap_result     res;
        mhpq_pkg::t_entry held;
        int unsigned      pos;
        int unsigned      parent;
        int unsigned      child;
        bit               sifting;

        res = '0;
        if (op == mhpq_pkg::OP_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                res.status = mhpq_pkg::STATUS_FULL;
            end else begin
                // Move every strictly costlier parent down one level.
                pos = shadow_count;
                shadow_count++;
                sifting = 1'b1;
                while (sifting && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if ($signed(cost) < $signed(shadow_heap[parent].cost)) begin
                        shadow_heap[pos] = shadow_heap[parent];
                        pos = parent;
                    end else begin
                        sifting = 1'b0;
                    end
                end
                shadow_heap[pos].vertex = vertex;
                shadow_heap[pos].cost   = cost;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = mhpq_pkg::STATUS_EMPTY;
            end else begin
                res.extracted = 1'b1;
                res.vertex    = shadow_heap[0].vertex;
                res.cost      = shadow_heap[0].cost;
                shadow_count--;
                shadow_heap[0] = shadow_heap[shadow_count];
                // Sift the moved entry down; ties keep the left child.
                pos = 0;
                sifting = 1'b1;
                while (sifting && 2 * pos + 1 < shadow_count) begin
                    child = 2 * pos + 1;
                    if (child + 1 < shadow_count &&
                        $signed(shadow_heap[child + 1].cost) <
                        $signed(shadow_heap[child].cost)) begin
                        child++;
                    end
                    if ($signed(shadow_heap[child].cost) <
                        $signed(shadow_heap[pos].cost)) begin
                        held               = shadow_heap[pos];
                        shadow_heap[pos]   = shadow_heap[child];
                        shadow_heap[child] = held;
                        pos = child;
                    end else begin
                        sifting = 1'b0;
                    end
                end
            end
        end
        res.occupancy = mhpq_pkg::OCC_W'(shadow_count);
        return res;
    endfunction

    // A command beat is predicted first, so a result on the same edge still
    // meets the oldest prediction.
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n !== 1'b1) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                expected_results.push_back(predict_heap_op(i_op, i_vertex_id, i_cost));
            end
            if (i_done === 1'b1) begin
                o_results_seen++;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result beat with nothing expected (vertex %0d cost %0d)",
                             $time, i_out_vertex, $signed(i_out_cost));
                end else begin
                    want = expected_results.pop_front();
                    if (want.extracted) o_pairs_seen++;
                    if (want.status == mhpq_pkg::STATUS_EMPTY) o_empty_seen++;
                    if (want.status == mhpq_pkg::STATUS_FULL)  o_full_seen++;
                    if (i_out_vertex !== want.vertex) begin
                        o_fail_count++;
                        $display("%0t: out_vertex mismatch, expected %0d, got %0d",
                                 $time, want.vertex, i_out_vertex);
                    end
                    if (i_out_cost !== want.cost) begin
                        o_fail_count++;
                        $display("%0t: out_cost mismatch, expected %0d, got %0d",
                                 $time, $signed(want.cost), $signed(i_out_cost));
                    end
                    if (i_status !== want.status) begin
                        o_fail_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, i_status);
                    end
                    if (i_occupancy !== want.occupancy) begin
                        o_fail_count++;
                        $display("%0t: occupancy mismatch, expected %0d, got %0d",
                                 $time, want.occupancy, i_occupancy);
                    end
                end
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

### tb/tb_min_heap_priority_queue.sv
`timescale 1ns / 1ps

module tb_min_heap_priority_queue;

    localparam int HEAP_CAP     = mhpq_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    logic                          i_op        = mhpq_pkg::OP_INSERT;
    logic [mhpq_pkg::VERTEX_W-1:0] i_vertex_id = '0;
    logic [mhpq_pkg::COST_W-1:0]   i_cost      = '0;
    logic                          o_done;
    logic [mhpq_pkg::VERTEX_W-1:0] o_out_vertex;
    logic [mhpq_pkg::COST_W-1:0]   o_out_cost;
    logic [mhpq_pkg::STATUS_W-1:0] o_status;
    logic [mhpq_pkg::OCC_W-1:0]    o_occupancy;

    int fail_count;
    int outstanding;
    int results_seen;
    int pairs_seen;
    int empty_seen;
    int full_seen;
    int cycle_count;
    // Entry count as the stimulus expects it; steers fill and drain phases.
    int fill_level = 0;

    min_heap_priority_queue #(
        .CAPACITY (HEAP_CAP)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_vertex_id  (i_vertex_id),
        .i_cost       (i_cost),
        .o_done       (o_done),
        .o_out_vertex (o_out_vertex),
        .o_out_cost   (o_out_cost),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    heap_result_checker #(
        .CAPACITY (HEAP_CAP)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_vertex_id    (i_vertex_id),
        .i_cost         (i_cost),
        .i_done         (o_done),
        .i_out_vertex   (o_out_vertex),
        .i_out_cost     (o_out_cost),
        .i_status       (o_status),
        .i_occupancy    (o_occupancy),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_results_seen (results_seen),
        .o_pairs_seen   (pairs_seen),
        .o_empty_seen   (empty_seen),
        .o_full_seen    (full_seen)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends a run that hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // Drives one command beat and holds it until the block takes it.
    task automatic issue_command(
        input logic                          op,
        input logic [mhpq_pkg::VERTEX_W-1:0] vertex,
        input logic [mhpq_pkg::COST_W-1:0]   cost
    );
        @(negedge i_clk);
        start       <= 1'b1;
        i_op        <= op;
        i_vertex_id <= vertex;
        i_cost      <= cost;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if (op == mhpq_pkg::OP_INSERT) begin
            if (fill_level < HEAP_CAP) fill_level++;
        end else if (fill_level > 0) begin
            fill_level--;
        end
    endtask

    // Leaves the command channel idle for the given number of cycles.
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Costs: full range, a narrow band that forces ties, and the extremes.
    function automatic logic [mhpq_pkg::COST_W-1:0] draw_cost();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return mhpq_pkg::COST_W'($urandom);
        if (pick < 8) return mhpq_pkg::COST_W'(int'($urandom_range(0, 15)) - 8);
        if (pick == 8) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if ($urandom_range(0, 1) == 0) return 32'h7FFF_FFFF - $urandom_range(0, 3);
        return 32'h8000_0000 + $urandom_range(0, 3);
    endfunction

    initial begin
        int  item;
        bit  draining;
        bit  burst;
        bit  do_insert;
        int  bound_hits;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty extracts, field extremes, equal costs, full drain.
        issue_command(mhpq_pkg::OP_EXTRACT, 16'h0000, 32'h0000_0000);
        issue_command(mhpq_pkg::OP_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF);
        issue_command(mhpq_pkg::OP_INSERT, 16'hFFFF, 32'h7FFF_FFFF);
        issue_command(mhpq_pkg::OP_INSERT, 16'h0000, 32'h8000_0000);
        issue_command(mhpq_pkg::OP_INSERT, 16'h1234, 32'h0000_0000);
        issue_command(mhpq_pkg::OP_INSERT, 16'h0005, 32'hFFFF_FFFF);
        issue_command(mhpq_pkg::OP_INSERT, 16'h0006, 32'hFFFF_FFFF);
        issue_command(mhpq_pkg::OP_INSERT, 16'h0007, 32'hFFFF_FFFF);
        issue_command(mhpq_pkg::OP_INSERT, 16'h0008, 32'h0000_0001);
        issue_command(mhpq_pkg::OP_INSERT, 16'h0009, 32'h0000_0000);
        repeat (8) issue_command(mhpq_pkg::OP_EXTRACT, mhpq_pkg::VERTEX_W'($urandom),
                                 mhpq_pkg::COST_W'($urandom));
        issue_command(mhpq_pkg::OP_EXTRACT, 16'hAAAA, 32'h5555_5555);
        issue_command(mhpq_pkg::OP_INSERT, 16'hAAAA, 32'h5555_5555);
        issue_command(mhpq_pkg::OP_INSERT, 16'h5555, 32'hAAAA_AAAA);
        issue_command(mhpq_pkg::OP_EXTRACT, 16'h0000, 32'h0000_0000);
        issue_command(mhpq_pkg::OP_EXTRACT, 16'h0000, 32'h0000_0000);
        hold_off(5);

        // Random: alternate fill and drain phases so the heap reaches both
        // full and empty, with bursts of back-to-back beats between gaps.
        draining   = 1'b0;
        burst      = 1'b0;
        bound_hits = 0;
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            if (!draining) do_insert = ($urandom_range(0, 99) < 80);
            else           do_insert = ($urandom_range(0, 99) < 22);
            issue_command(do_insert ? mhpq_pkg::OP_INSERT : mhpq_pkg::OP_EXTRACT,
                          mhpq_pkg::VERTEX_W'($urandom), draw_cost());
            if (!draining && fill_level == HEAP_CAP) begin
                bound_hits++;
                if (bound_hits > 3) begin
                    draining   = 1'b1;
                    bound_hits = 0;
                end
            end else if (draining && fill_level == 0) begin
                bound_hits++;
                if (bound_hits > 2) begin
                    draining   = 1'b0;
                    bound_hits = 0;
                end
            end
            hold_off(burst ? 0 : draw_gap());
        end

        // Let the last results come out, then allow time for strays.
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d results: %0d popped pairs, %0d pops of an empty heap,",
                 results_seen, pairs_seen, empty_seen);
        $display("%0d pushes into a full heap, %0d failures.", full_seen, fail_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
